// File: sv/ldsif_pkg.sv
`timescale 1ns / 1ps
// Types and register codes for the LED dim smoother with identify flash.
// No dependencies; used by the top level and its checker.
`default_nettype none

package ldsif_pkg;

  localparam int TARGET_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 3;
  localparam int MAX_CH   = 6;

  localparam logic [CFG_IX_W-1:0] REG_SMOOTH_DIV = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_ON_ANALOG  = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_OFF_ANALOG = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_ON_DIGITAL = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_HALF_PER   = 3'd4;
  localparam logic [CFG_IX_W-1:0] REG_PAUSE      = 3'd5;
  localparam logic [CFG_IX_W-1:0] REG_GROUP      = 3'd6;

  typedef struct packed {
    logic        identify;
    logic [15:0] target_a;
    logic [15:0] target_b;
    logic [15:0] target_c;
    logic [15:0] target_d;
    logic [15:0] target_e;
    logic [15:0] target_f;
  } in_t;

  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic [15:0] compare_d;
    logic [15:0] compare_e;
    logic [15:0] compare_f;
    logic [5:0]  analog_write_mask;
    logic [15:0] digital_level;
    logic        digital_write;
  } out_t;

endpackage

`default_nettype wire

// File: sv/led_dim_smoother_identify_flash_top.sv
`timescale 1ns / 1ps
// LED dim smoother with identify flash: top level, one shared divider.
// Depends on ldsif_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one beat per PWM period: the identify
//   flag and six analog targets. out_valid/out_ready/out_data return exactly
//   one beat per input beat. cfg_we/cfg_index/cfg_data write the registers,
//   only while the block is idle; the block itself does not enforce this.
// Flow: an identify beat goes straight to the output register. A normal beat
//   scans the channels and, for each one that is smoothed, runs the shared
//   restoring divider, retiring one quotient bit a cycle, before applying
//   the new level. One beat is in work at a time.
// The output register holds a finished beat while the next input is taken;
//   a stalled receiver only holds the block once the next result is ready.
// Reset (rst, synchronous) clears the levels, flash state, output valid and
//   loads the register defaults.
`default_nettype none

module led_dim_smoother_identify_flash_top #(
  parameter int CHANNELS      = 6,
  parameter int FRACTION_BITS = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  ldsif_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output ldsif_pkg::out_t                  out_data,
  input  wire                              cfg_we,
  input  wire  [ldsif_pkg::CFG_IX_W-1:0]   cfg_index,
  input  wire  [ldsif_pkg::CFG_W-1:0]      cfg_data
);
  import ldsif_pkg::*;

  localparam int LW    = 16 + FRACTION_BITS;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW  = $clog2(CHANNELS + 1);
  localparam int DCW   = $clog2(LW + 1);
  localparam logic [5:0] ALL_CH = 6'((1 << CHANNELS) - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DIV   = 5'b00100,
    S_APPLY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  // registers
  logic [7:0]  smooth_div;
  logic [15:0] on_analog, off_analog, on_digital, half_per, pause;
  logic [3:0]  group;

  // flash state
  logic        was_ident, flash_on;
  logic [15:0] flash_timer;
  logic [3:0]  toggle_cnt;

  logic [LW-1:0] level [CHANNELS];
  logic [15:0]   tgt [MAX_CH];
  logic [15:0]   cmp [MAX_CH];
  logic [5:0]    mask;
  logic [15:0]   dig_level;
  logic          dig_write;
  logic          exiting;

  logic [CNTW-1:0] ch;
  logic [DCW-1:0]  dcnt;
  logic [8:0]      rem;
  logic [LW-1:0]   quo;
  logic [LW-1:0]   tval;
  logic            below;

  // datapath
  logic [7:0]    divq;
  logic [CW-1:0] ci;
  logic [2:0]    ci6;
  logic [15:0]   cur_tgt;
  logic [LW-1:0] cur_lvl, cur_t;
  logic [8:0]    rem_sh;
  logic          ge;
  logic [LW-1:0] new_lvl;
  logic [15:0]   timer_dec;
  logic [3:0]    cnt_inc, grp;
  logic          flash_next;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign divq     = (smooth_div == 8'd0) ? 8'd1 : smooth_div;
  assign ci       = ch[CW-1:0];
  assign ci6      = 3'(ch);
  assign cur_tgt  = exiting ? off_analog : tgt[ci6];
  assign cur_lvl  = level[ci];
  assign cur_t    = {cur_tgt, {FRACTION_BITS{1'b0}}};
  assign rem_sh   = {rem[7:0], quo[LW-1]};
  assign ge       = rem_sh >= {1'b0, divq};
  assign new_lvl  = below ? (tval - quo) : (tval + quo);
  assign timer_dec  = flash_timer - 16'd1;
  assign cnt_inc    = toggle_cnt + 4'd1;
  assign grp        = (group == 4'd0) ? 4'd1 : group;
  assign flash_next = !flash_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_div <= 8'd4;
      on_analog  <= 16'd0;
      off_analog <= 16'd0;
      on_digital <= 16'hFFFF;
      half_per   <= 16'd250;
      pause      <= 16'd1000;
      group      <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTH_DIV: smooth_div <= cfg_data[7:0];
        REG_ON_ANALOG:  on_analog  <= cfg_data;
        REG_OFF_ANALOG: off_analog <= cfg_data;
        REG_ON_DIGITAL: on_digital <= cfg_data;
        REG_HALF_PER:   half_per   <= cfg_data;
        REG_PAUSE:      pause      <= cfg_data;
        REG_GROUP:      group      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      was_ident   <= 1'b0;
      flash_on    <= 1'b0;
      flash_timer <= 16'd250;
      toggle_cnt  <= 4'd0;
      out_valid   <= 1'b0;
      for (int n = 0; n < CHANNELS; n++) begin
        level[n] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            tgt[0] <= in_data.target_a;
            tgt[1] <= in_data.target_b;
            tgt[2] <= in_data.target_c;
            tgt[3] <= in_data.target_d;
            tgt[4] <= in_data.target_e;
            tgt[5] <= in_data.target_f;
            ch      <= '0;
            exiting <= !in_data.identify && was_ident;
            if (in_data.identify) begin
              was_ident <= 1'b1;
              state     <= S_DONE;
              if (timer_dec == 16'd0) begin
                flash_on  <= flash_next;
                dig_write <= 1'b1;
                dig_level <= flash_next ? on_digital : 16'd0;
                mask      <= ALL_CH;
                for (int n = 0; n < MAX_CH; n++) begin
                  cmp[n] <= (n < CHANNELS) ? (flash_next ? on_analog : off_analog) : 16'd0;
                end
                if (cnt_inc >= grp) begin
                  flash_timer <= pause;
                  toggle_cnt  <= 4'd0;
                end else begin
                  flash_timer <= half_per;
                  toggle_cnt  <= cnt_inc;
                end
              end else begin
                flash_timer <= timer_dec;
                dig_write   <= 1'b0;
                dig_level   <= 16'd0;
                mask        <= 6'd0;
                for (int n = 0; n < MAX_CH; n++) begin
                  cmp[n] <= 16'd0;
                end
              end
            end else begin
              state     <= S_SCAN;
              was_ident <= 1'b0;
              dig_write <= was_ident;
              dig_level <= 16'd0;
              mask      <= was_ident ? ALL_CH : 6'd0;
              for (int n = 0; n < MAX_CH; n++) begin
                cmp[n] <= (was_ident && n < CHANNELS) ? off_analog : 16'd0;
              end
            end
          end
        end
        S_SCAN: begin
          if (ch == CNTW'(CHANNELS)) begin
            state <= S_DONE;
          end else if (cur_tgt == cur_lvl[LW-1:FRACTION_BITS]) begin
            ch <= ch + 1'b1;
          end else begin
            tval  <= cur_t;
            below <= cur_lvl < cur_t;
            quo   <= (cur_lvl < cur_t) ? (cur_t - cur_lvl) : (cur_lvl - cur_t);
            rem   <= 9'd0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? (rem_sh - {1'b0, divq}) : rem_sh;
          quo  <= {quo[LW-2:0], ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(LW - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          level[ci] <= new_lvl;
          cmp[ci6]  <= new_lvl[LW-1:FRACTION_BITS];
          mask[ci6] <= 1'b1;
          ch        <= ch + 1'b1;
          state     <= S_SCAN;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid                  <= 1'b1;
            out_data.compare_a         <= cmp[0];
            out_data.compare_b         <= cmp[1];
            out_data.compare_c         <= cmp[2];
            out_data.compare_d         <= cmp[3];
            out_data.compare_e         <= cmp[4];
            out_data.compare_f         <= cmp[5];
            out_data.analog_write_mask <= mask;
            out_data.digital_level     <= dig_level;
            out_data.digital_write     <= dig_write;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/ldsif_check.sv
`timescale 1ns / 1ps
// Port-level checks for the LED dim smoother, bound to the top level.
// Depends on ldsif_pkg and led_dim_smoother_identify_flash_top.
`default_nettype none

module ldsif_check (
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input ldsif_pkg::out_t out_data
);
  import ldsif_pkg::*;

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one beat in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_dig_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.digital_write |-> out_data.digital_level == 16'd0)
    else $error("digital level without write");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.analog_write_mask[0] |-> out_data.compare_a == 16'd0)
    else $error("channel 0 compare without write");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind led_dim_smoother_identify_flash_top ldsif_check u_ldsif_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for led_dim_smoother_identify_flash_top: directed and random PWM ticks,
// every result beat checked field by field against a behavioural filter/flash model.
// Depends on ldsif_pkg and the top level in sv/.

module tb_top;
  import ldsif_pkg::*;

  localparam int LIMIT = 1_500_000;
  localparam int CH    = 6;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  // behavioural copy of the block: levels, flash state, registers
  logic [23:0] level_q [CH];
  logic        ident_q, lit_q;
  logic [15:0] timer_q;
  logic [3:0]  toggles_q;
  logic [7:0]  r_div;
  logic [15:0] r_on_a, r_off_a, r_on_d, r_half, r_pause;
  logic [3:0]  r_group;

  out_t due_q [$];
  out_t want_b;
  int   errors     = 0;
  int   stall_left = 0;
  int   cycles     = 0;
  bit   idle_on    = 1'b1;

  always #2 clk = ~clk;

  led_dim_smoother_identify_flash_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [23:0] ease_level(logic [23:0] old, logic [15:0] goal,
                                             logic [7:0] dv);
    logic [23:0] t;
    t = {goal, 8'h00};
    if (old >= t) return t + (old - t) / dv;
    return t - (t - old) / dv;
  endfunction

  function automatic out_t dim_tick(in_t b);
    out_t        r;
    logic [15:0] tg [CH];
    logic [15:0] cmp [CH];
    logic [15:0] lvl, goal;
    logic [5:0]  mask;
    logic [7:0]  dv;
    logic [3:0]  grp;
    logic        leaving;
    r    = '0;
    mask = '0;
    dv   = (r_div == 8'd0) ? 8'd1 : r_div;
    tg   = '{b.target_a, b.target_b, b.target_c, b.target_d, b.target_e, b.target_f};
    foreach (cmp[n]) cmp[n] = '0;
    if (b.identify) begin
      ident_q = 1'b1;
      timer_q = timer_q - 16'd1;
      if (timer_q == 16'd0) begin
        grp       = (r_group == 4'd0) ? 4'd1 : r_group;
        timer_q   = r_half;
        lit_q     = !lit_q;
        lvl       = lit_q ? r_on_a : r_off_a;
        r.digital_level = lit_q ? r_on_d : 16'd0;
        r.digital_write = 1'b1;
        toggles_q = toggles_q + 4'd1;
        if (toggles_q >= grp) begin
          timer_q   = r_pause;
          toggles_q = '0;
        end
        foreach (cmp[n]) cmp[n] = lvl;
        mask = '1;
      end
    end else begin
      leaving = ident_q;
      if (leaving) begin
        ident_q = 1'b0;
        foreach (cmp[n]) cmp[n] = r_off_a;
        mask = '1;
        r.digital_write = 1'b1;
      end
      for (int n = 0; n < CH; n++) begin
        goal = leaving ? r_off_a : tg[n];
        if (goal != level_q[n][23:8]) begin
          level_q[n] = ease_level(level_q[n], goal, dv);
          cmp[n]     = level_q[n][23:8];
          mask[n]    = 1'b1;
        end
      end
    end
    r.compare_a         = cmp[0];
    r.compare_b         = cmp[1];
    r.compare_c         = cmp[2];
    r.compare_d         = cmp[3];
    r.compare_e         = cmp[4];
    r.compare_f         = cmp[5];
    r.analog_write_mask = mask;
    return r;
  endfunction

  function automatic in_t tick_of(logic id, logic [95:0] t);
    return {id, t};
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  // one input beat; valid held from the previous beat unless a gap is taken
  task automatic send_tick(in_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    due_q.push_back(dim_tick(b));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (ix)
      REG_SMOOTH_DIV: r_div   = v[7:0];
      REG_ON_ANALOG:  r_on_a  = v;
      REG_OFF_ANALOG: r_off_a = v;
      REG_ON_DIGITAL: r_on_d  = v;
      REG_HALF_PER:   r_half  = v;
      REG_PAUSE:      r_pause = v;
      REG_GROUP:      r_group = v[3:0];
      default: ;
    endcase
  endtask

  task automatic setup_phase(logic [7:0] dv, logic [3:0] grp);
    set_reg(REG_SMOOTH_DIV, 16'(dv));
    set_reg(REG_ON_ANALOG, pick_level());
    set_reg(REG_OFF_ANALOG, pick_level());
    set_reg(REG_ON_DIGITAL, pick_level());
    set_reg(REG_HALF_PER, 16'($urandom_range(1, 6)));
    set_reg(REG_PAUSE, 16'($urandom_range(1, 12)));
    set_reg(REG_GROUP, 16'(grp));
  endtask

  task automatic test_defaults();
    send_tick(tick_of(1'b0, {6{16'h0000}}));
    send_tick(tick_of(1'b0, {16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'h00FF, 16'hFF00}));
    send_tick(tick_of(1'b1, {6{16'hA5A5}}));
    send_tick(tick_of(1'b1, {6{16'h5A5A}}));
    send_tick(tick_of(1'b0, {6{16'h1234}}));
    settle();
  endtask

  task automatic test_smoothing();
    set_reg(REG_SMOOTH_DIV, 16'd1);
    send_tick(tick_of(1'b0, {6{16'hFFFF}}));
    send_tick(tick_of(1'b0, {6{16'hFFFF}}));
    settle();
    set_reg(REG_SMOOTH_DIV, 16'd0);
    send_tick(tick_of(1'b0, {6{16'h0000}}));
    settle();
    set_reg(REG_SMOOTH_DIV, 16'd255);
    send_tick(tick_of(1'b0, {3{16'hFFFF, 16'h0000}}));
    send_tick(tick_of(1'b0, {3{16'h0000, 16'hFFFF}}));
    send_tick(tick_of(1'b0, {3{16'hFFFF, 16'h0000}}));
    settle();
  endtask

  task automatic test_flash();
    set_reg(REG_SMOOTH_DIV, 16'd4);
    set_reg(REG_ON_ANALOG, 16'hFFFF);
    set_reg(REG_OFF_ANALOG, 16'h0000);
    set_reg(REG_ON_DIGITAL, 16'hFFFF);
    set_reg(REG_HALF_PER, 16'd1);
    set_reg(REG_PAUSE, 16'd2);
    set_reg(REG_GROUP, 16'd0);
    repeat (6) send_tick(tick_of(1'b1, {$urandom, $urandom, $urandom}));
    send_tick(tick_of(1'b0, {6{16'h7777}}));
    settle();
    // long group, inverted levels, exit smooths towards a full-scale off level
    set_reg(REG_ON_ANALOG, 16'h0000);
    set_reg(REG_OFF_ANALOG, 16'hFFFF);
    set_reg(REG_ON_DIGITAL, 16'h0000);
    set_reg(REG_HALF_PER, 16'd2);
    set_reg(REG_PAUSE, 16'd1);
    set_reg(REG_GROUP, 16'd15);
    repeat (6) send_tick(tick_of(1'b1, {6{16'h0000}}));
    send_tick(tick_of(1'b0, {6{16'h0000}}));
    send_tick(tick_of(1'b0, {6{16'h0000}}));
    settle();
  endtask

  task automatic test_random(int count);
    logic [15:0] goal [CH];
    int          hold, left;
    left = count;
    foreach (goal[c]) goal[c] = 16'($urandom);
    while (left > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 20);
        for (int k = 0; k < hold && left > 0; k++) begin
          send_tick(tick_of(1'b1, {$urandom, $urandom, $urandom}));
          left--;
        end
      end else begin
        foreach (goal[c]) begin
          case ($urandom_range(0, 7))
            0, 1: ;
            2, 3: goal[c] = 16'($urandom);
            4, 5: goal[c] = goal[c] + 16'($urandom_range(0, 600)) - 16'd300;
            6:    goal[c] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            7:    goal[c] = level_q[c][23:8];
            default: ;
          endcase
        end
        hold = $urandom_range(1, 8);
        for (int k = 0; k < hold && left > 0; k++) begin
          send_tick(tick_of(1'b0, {goal[0], goal[1], goal[2], goal[3], goal[4], goal[5]}));
          left--;
        end
      end
    end
    settle();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    stall_left = 1000;
    for (int k = 0; k < 12; k++)
      send_tick(tick_of(k % 4 == 3, {$urandom, $urandom, $urandom}));
    settle();
  endtask

  task automatic test_sender_pause();
    repeat (10) send_tick(tick_of(1'($urandom_range(0, 1)), {$urandom, $urandom, $urandom}));
    settle();
    repeat (10) send_tick(tick_of(1'($urandom_range(0, 1)), {$urandom, $urandom, $urandom}));
    settle();
  endtask

  // a zero reload makes the next identify tick wrap the timer instead of flashing
  task automatic test_timer_wrap();
    set_reg(REG_HALF_PER, 16'd0);
    set_reg(REG_PAUSE, 16'd0);
    while (timer_q != 16'd0) send_tick(tick_of(1'b1, {$urandom, $urandom, $urandom}));
    repeat (3) send_tick(tick_of(1'b1, {$urandom, $urandom, $urandom}));
    settle();
    set_reg(REG_HALF_PER, 16'hFFFF);
    set_reg(REG_PAUSE, 16'hFFFF);
    send_tick(tick_of(1'b1, {6{16'hFFFF}}));
    send_tick(tick_of(1'b0, {6{16'h4321}}));
    send_tick(tick_of(1'b0, {6{16'h4321}}));
    settle();
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want_b = due_q.pop_front();
        check_field("compare_a", out_data.compare_a, want_b.compare_a);
        check_field("compare_b", out_data.compare_b, want_b.compare_b);
        check_field("compare_c", out_data.compare_c, want_b.compare_c);
        check_field("compare_d", out_data.compare_d, want_b.compare_d);
        check_field("compare_e", out_data.compare_e, want_b.compare_e);
        check_field("compare_f", out_data.compare_f, want_b.compare_f);
        check_field("analog_write_mask", 16'(out_data.analog_write_mask),
                    16'(want_b.analog_write_mask));
        check_field("digital_level", out_data.digital_level, want_b.digital_level);
        check_field("digital_write", 16'(out_data.digital_write),
                    16'(want_b.digital_write));
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    r_div   = 8'd4;
    r_on_a  = 16'h0000;
    r_off_a = 16'h0000;
    r_on_d  = 16'hFFFF;
    r_half  = 16'd250;
    r_pause = 16'd1000;
    r_group = 4'd8;
    foreach (level_q[n]) level_q[n] = '0;
    ident_q   = 1'b0;
    lit_q     = 1'b0;
    timer_q   = 16'd250;
    toggles_q = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_smoothing();
    test_flash();
    setup_phase(8'd2, 4'd1);
    test_random(350);
    setup_phase(8'd255, 4'd15);
    test_random(350);
    test_backpressure();
    setup_phase(8'd1, 4'd0);
    test_random(350);
    test_sender_pause();
    setup_phase(8'($urandom_range(3, 40)), 4'($urandom_range(2, 9)));
    test_random(350);
    idle_on = 1'b0;
    setup_phase(8'd4, 4'd8);
    test_random(180);
    test_timer_wrap();

    settle();
    repeat (160) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
